// ----- design/tbar_pkg.sv -----
// Shared types and constants for the two-button auto-repeat block.
// Standalone package; used by tbar_ctrl and two_button_auto_repeat.
`default_nettype none

package tbar_pkg;

   localparam int unsigned TIME_W    = 32;
   localparam int unsigned DELAY_W   = 16;
   localparam int unsigned ID_W      = 5;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DELAY     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_INTERVAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_ONE_ID   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_TWO_ID   = 3'd4;

   // register reset values
   localparam logic                 ENABLED_RST         = 1'b1;
   localparam logic [DELAY_W-1:0]   FIRST_DELAY_RST     = 16'd500;
   localparam logic [DELAY_W-1:0]   REPEAT_INTERVAL_RST = 16'd100;
   localparam logic [ID_W-1:0]      BUTTON_ONE_ID_RST   = 5'd0;
   localparam logic [ID_W-1:0]      BUTTON_TWO_ID_RST   = 5'd1;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_ONE  = 2'd1,
      DIR_TWO  = 2'd2
   } dir_type;

   typedef struct packed {
      logic              one_changed;
      logic              one_pressed;
      logic              two_changed;
      logic              two_pressed;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic            fire;
      logic [ID_W-1:0] fired_id;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/two_button_auto_repeat.sv -----
// Auto-repeat for a pair of opposing buttons: one response per request, giving
// fire and the id of the firing button. Each request is captured in an input
// register, decided by short compare/subtract logic against the direction and
// repeat-timer state, and written to a two-entry response buffer (output
// register plus skid). Throughput is one request per clock while the skid
// entry is empty; a request passes the input register, then the output
// register. The skid entry lets the block take one more request while a
// response waits on rsp_ready. The user must write the registers through the
// csr port only while no request is in flight; the block does not enforce it.
// Depends on tbar_pkg and tbar_ctrl.
`default_nettype none

module two_button_auto_repeat (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire tbar_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output tbar_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [tbar_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tbar_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   logic               in_valid_ff;
   tbar_pkg::req_type  in_data_ff;
   logic               advance;
   tbar_pkg::rsp_type  result;

   logic               head_valid_ff, head_valid_in;
   tbar_pkg::rsp_type  head_ff, head_in;
   logic               skid_valid_ff, skid_valid_in;
   tbar_pkg::rsp_type  skid_ff, skid_in;
   logic               pop;

   assign advance   = in_valid_ff && !skid_valid_ff;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   tbar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (advance),
      .req       (in_data_ff),
      .rsp       (result)
   );

   assign pop = head_valid_ff && rsp_ready;

   always_comb begin
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!head_valid_ff || pop) begin
         if (skid_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = skid_ff;
            skid_valid_in = advance;
            skid_in       = result;
         end else begin
            head_valid_in = advance;
            head_in       = result;
         end
      end else if (advance) begin
         // head stalled: park the new response
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = head_valid_ff;
   assign rsp_data  = head_ff;

endmodule

`default_nettype wire

// ----- design/tbar_ctrl.sv -----
// Configuration registers, direction/timer state and the per-request decision.
// Depends on tbar_pkg.
`default_nettype none

module tbar_ctrl (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [tbar_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tbar_pkg::CSR_DAT_W-1:0]     csr_wdata,
   input  wire logic                               advance,
   input  wire tbar_pkg::req_type                  req,
   output tbar_pkg::rsp_type                       rsp
);

   logic                               enabled_ff;
   logic [tbar_pkg::DELAY_W-1:0]       first_delay_ff;
   logic [tbar_pkg::DELAY_W-1:0]       repeat_interval_ff;
   logic [tbar_pkg::ID_W-1:0]          button_one_id_ff;
   logic [tbar_pkg::ID_W-1:0]          button_two_id_ff;

   tbar_pkg::dir_type                  direction_ff, direction_in;
   logic                               running_ff, running_in;
   logic [tbar_pkg::TIME_W-1:0]        start_ff, start_in;
   logic                               use_first_ff, use_first_in;

   logic                               changed;
   logic                               mine;
   logic                               other;
   tbar_pkg::dir_type                  me_dir;
   tbar_pkg::dir_type                  other_dir;
   logic [tbar_pkg::ID_W-1:0]          me_id;
   logic [tbar_pkg::DELAY_W-1:0]       limit;
   logic [tbar_pkg::TIME_W-1:0]        elapsed;
   logic                               expired;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff         <= tbar_pkg::ENABLED_RST;
         first_delay_ff     <= tbar_pkg::FIRST_DELAY_RST;
         repeat_interval_ff <= tbar_pkg::REPEAT_INTERVAL_RST;
         button_one_id_ff   <= tbar_pkg::BUTTON_ONE_ID_RST;
         button_two_id_ff   <= tbar_pkg::BUTTON_TWO_ID_RST;
      end else if (csr_we) begin
         case (csr_index)
            tbar_pkg::CSR_ENABLED: begin
               enabled_ff <= csr_wdata[0];
            end
            tbar_pkg::CSR_FIRST_DELAY: begin
               first_delay_ff <= csr_wdata;
            end
            tbar_pkg::CSR_REPEAT_INTERVAL: begin
               repeat_interval_ff <= csr_wdata;
            end
            tbar_pkg::CSR_BUTTON_ONE_ID: begin
               button_one_id_ff <= csr_wdata[tbar_pkg::ID_W-1:0];
            end
            tbar_pkg::CSR_BUTTON_TWO_ID: begin
               button_two_id_ff <= csr_wdata[tbar_pkg::ID_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // button one change wins over button two
   assign changed   = req.one_changed | req.two_changed;
   assign mine      = req.one_changed ? req.one_pressed : req.two_pressed;
   assign other     = req.one_changed ? req.two_pressed : req.one_pressed;
   assign me_dir    = req.one_changed ? tbar_pkg::DIR_ONE : tbar_pkg::DIR_TWO;
   assign other_dir = req.one_changed ? tbar_pkg::DIR_TWO : tbar_pkg::DIR_ONE;
   assign me_id     = req.one_changed ? button_one_id_ff : button_two_id_ff;

   assign limit   = use_first_ff ? first_delay_ff : repeat_interval_ff;
   assign elapsed = req.now_ms - start_ff;
   assign expired = (elapsed[tbar_pkg::TIME_W-1:tbar_pkg::DELAY_W] != '0) ||
                    (elapsed[tbar_pkg::DELAY_W-1:0] >= limit);

   always_comb begin
      direction_in = direction_ff;
      running_in   = running_ff;
      start_in     = start_ff;
      use_first_in = use_first_ff;
      rsp.fire     = 1'b0;
      rsp.fired_id = '0;
      if (!enabled_ff) begin
         running_in = 1'b0;
      end else if (changed) begin
         if (mine) begin
            // press only counts while the opposite button is up
            if (!other) begin
               direction_in = me_dir;
               running_in   = 1'b1;
               start_in     = req.now_ms;
               use_first_in = 1'b1;
               rsp.fire     = 1'b1;
               rsp.fired_id = me_id;
            end
         end else if (direction_ff == me_dir) begin
            if (other) begin
               // hand over to the held button, no fire
               direction_in = other_dir;
               running_in   = 1'b1;
               start_in     = req.now_ms;
               use_first_in = 1'b1;
            end else begin
               direction_in = tbar_pkg::DIR_NONE;
               running_in   = 1'b0;
            end
         end
      end else if (running_ff && expired) begin
         start_in     = req.now_ms;
         use_first_in = 1'b0;
         rsp.fire     = 1'b1;
         rsp.fired_id = (direction_ff == tbar_pkg::DIR_ONE) ? button_one_id_ff
                                                             : button_two_id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= tbar_pkg::DIR_NONE;
         running_ff   <= 1'b0;
         start_ff     <= '0;
         use_first_ff <= 1'b1;
      end else if (csr_we && (csr_index == tbar_pkg::CSR_ENABLED) && !csr_wdata[0]) begin
         running_ff <= 1'b0;
      end else if (advance) begin
         direction_ff <= direction_in;
         running_ff   <= running_in;
         start_ff     <= start_in;
         use_first_ff <= use_first_in;
      end
   end

endmodule

`default_nettype wire

// ----- tb/two_button_auto_repeat_tb.sv -----
`timescale 1ns / 100ps
// Testbench for two_button_auto_repeat: directed and random button/time requests
// checked in order against an untimed model of the direction and repeat timer.
// Depends on tbar_pkg and the two_button_auto_repeat RTL.

module two_button_auto_repeat_tb;
   import tbar_pkg::*;

   localparam int CLK_HALF     = 2;
   localparam int RESET_CYCLES = 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int RUN_LIMIT_NS = 4_000_000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   two_button_auto_repeat dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Verification failed");
      $finish;
   end

   // model of the block's registers and state
   logic                m_enabled;
   logic [DELAY_W-1:0]  m_first_delay;
   logic [DELAY_W-1:0]  m_repeat;
   logic [ID_W-1:0]     m_id_one;
   logic [ID_W-1:0]     m_id_two;
   dir_type             m_dir;
   logic                m_running;
   logic [TIME_W-1:0]   m_start;
   logic                m_use_first;

   req_type             pend_q[$];
   rsp_type             fire_q[$];
   int                  fail_cnt    = 0;
   int                  send_idle   = 0;
   int                  recv_idle   = 0;
   int                  hold_asked  = 0;
   int                  hold_served = 0;
   int                  hold_left   = 0;
   logic                req_taken   = 1'b0;

   // stimulus view of the real buttons and the clock in ms
   logic                lvl_one  = 1'b0;
   logic                lvl_two  = 1'b0;
   logic [TIME_W-1:0]   t_cursor = '0;

   function automatic logic button_edge(input dir_type me, input dir_type other,
                                        input logic mine, input logic other_lvl,
                                        input logic [TIME_W-1:0] now);
      logic fired;
      fired = 1'b0;
      if (mine) begin
         // press only counts when the opposing button is up
         if (!other_lvl) begin
            m_dir       = me;
            m_running   = 1'b1;
            m_start     = now;
            m_use_first = 1'b1;
            fired       = 1'b1;
         end
      end else if (m_dir == me) begin
         if (other_lvl) begin
            m_dir       = other;
            m_running   = 1'b1;
            m_start     = now;
            m_use_first = 1'b1;
         end else begin
            m_dir     = DIR_NONE;
            m_running = 1'b0;
         end
      end
      return fired;
   endfunction

   function automatic rsp_type predict_fire(input req_type r);
      rsp_type           o;
      logic [TIME_W-1:0] lim;
      logic [TIME_W-1:0] elapsed;
      o = '0;
      if (!m_enabled) begin
         m_running = 1'b0;
      end else if (r.one_changed) begin
         if (button_edge(DIR_ONE, DIR_TWO, r.one_pressed, r.two_pressed, r.now_ms)) begin
            o.fire     = 1'b1;
            o.fired_id = m_id_one;
         end
      end else if (r.two_changed) begin
         if (button_edge(DIR_TWO, DIR_ONE, r.two_pressed, r.one_pressed, r.now_ms)) begin
            o.fire     = 1'b1;
            o.fired_id = m_id_two;
         end
      end else if (m_running) begin
         lim     = m_use_first ? TIME_W'(m_first_delay) : TIME_W'(m_repeat);
         elapsed = r.now_ms - m_start;
         if (elapsed >= lim) begin
            o.fire      = 1'b1;
            o.fired_id  = (m_dir == DIR_ONE) ? m_id_one : m_id_two;
            m_start     = r.now_ms;
            m_use_first = 1'b0;
         end
      end
      return o;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pend_q.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_valid <= 1'b1;
            req_data  <= pend_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         rsp_ready   <= 1'b0;
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // monitor: predict on request accept, check on response accept
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) fire_q.push_back(predict_fire(req_data));
         if (rsp_valid && rsp_ready) begin
            if (fire_q.size() == 0) begin
               $error("unexpected response: fire=%0d fired_id=%0d",
                      rsp_data.fire, rsp_data.fired_id);
               fail_cnt++;
            end else begin
               want = fire_q.pop_front();
               if (want.fire !== rsp_data.fire) begin
                  $error("fire mismatch: expected %0d, actual %0d", want.fire, rsp_data.fire);
                  fail_cnt++;
               end
               if (want.fired_id !== rsp_data.fired_id) begin
                  $error("fired_id mismatch: expected %0d, actual %0d",
                         want.fired_id, rsp_data.fired_id);
                  fail_cnt++;
               end
            end
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ENABLED: begin
            m_enabled = val[0];
            if (!val[0]) m_running = 1'b0;
         end
         CSR_FIRST_DELAY:     m_first_delay = val[DELAY_W-1:0];
         CSR_REPEAT_INTERVAL: m_repeat      = val[DELAY_W-1:0];
         CSR_BUTTON_ONE_ID:   m_id_one      = val[ID_W-1:0];
         CSR_BUTTON_TWO_ID:   m_id_two      = val[ID_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_setup();
      write_reg(CSR_ENABLED, 16'(1));
      write_reg(CSR_FIRST_DELAY, 16'($urandom_range(40)));
      write_reg(CSR_REPEAT_INTERVAL, 16'($urandom_range(12)));
      write_reg(CSR_BUTTON_ONE_ID, 16'($urandom));
      write_reg(CSR_BUTTON_TWO_ID, 16'($urandom));
      @(posedge clock);
   endtask

   task automatic push_req(input logic c1, input logic p1, input logic c2, input logic p2,
                           input logic [TIME_W-1:0] now);
      req_type r;
      r.one_changed = c1;
      r.one_pressed = p1;
      r.two_changed = c2;
      r.two_pressed = p2;
      r.now_ms      = now;
      pend_q.push_back(r);
   endtask

   // mostly well-formed press/release traffic on a rising clock, plus noise
   task automatic gen_presses(input int count, input int step_max, input int noise_pct);
      req_type r;
      int      pick;
      for (int i = 0; i < count; i++) begin
         pick     = $urandom_range(99);
         t_cursor = t_cursor + TIME_W'($urandom_range(step_max));
         r        = '0;
         if (pick < noise_pct) begin
            r.one_changed = 1'($urandom_range(1));
            r.one_pressed = 1'($urandom_range(1));
            r.two_changed = 1'($urandom_range(1));
            r.two_pressed = 1'($urandom_range(1));
            r.now_ms      = $urandom;
         end else begin
            if (pick < noise_pct + 16) begin
               lvl_one       = !lvl_one;
               r.one_changed = 1'b1;
               if ($urandom_range(9) == 0) begin
                  lvl_two       = !lvl_two;
                  r.two_changed = 1'b1;
               end
            end else if (pick < noise_pct + 32) begin
               lvl_two       = !lvl_two;
               r.two_changed = 1'b1;
            end else if (pick < noise_pct + 37) begin
               // change flag with no real level change
               r.one_changed = 1'($urandom_range(1));
               r.two_changed = !r.one_changed;
            end
            r.one_pressed = lvl_one;
            r.two_pressed = lvl_two;
            r.now_ms      = t_cursor;
         end
         pend_q.push_back(r);
      end
   endtask

   task automatic drain_all();
      while (pend_q.size() != 0 || req_valid || fire_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_idle(input int s, input int r);
      send_idle = s;
      recv_idle = r;
   endtask

   initial begin
      m_enabled     = ENABLED_RST;
      m_first_delay = FIRST_DELAY_RST;
      m_repeat      = REPEAT_INTERVAL_RST;
      m_id_one      = BUTTON_ONE_ID_RST;
      m_id_two      = BUTTON_TWO_ID_RST;
      m_dir         = DIR_NONE;
      m_running     = 1'b0;
      m_start       = '0;
      m_use_first   = 1'b1;
      set_idle(32, 71);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset register values
      push_req(0, 0, 0, 0, 32'd0);
      push_req(1, 1, 0, 0, 32'd10);
      push_req(0, 1, 0, 0, 32'd509);
      push_req(0, 1, 0, 0, 32'd510);
      push_req(0, 1, 0, 0, 32'd609);
      push_req(0, 1, 0, 0, 32'd610);
      push_req(0, 1, 1, 1, 32'd620);   // press of two while one held
      push_req(1, 0, 0, 1, 32'd630);   // hand-over to two
      push_req(0, 0, 0, 1, 32'd1129);
      push_req(0, 0, 0, 1, 32'd1130);
      push_req(1, 1, 0, 1, 32'd1140);
      push_req(1, 0, 0, 1, 32'd1150);  // release of inactive button
      push_req(0, 0, 1, 0, 32'd1160);
      push_req(0, 0, 0, 0, 32'd5000);
      push_req(1, 1, 1, 0, 32'd5010);  // both changed, one wins
      push_req(1, 0, 1, 0, 32'd5020);
      push_req(0, 0, 1, 1, 32'hFFFF_FF00);
      push_req(0, 0, 0, 1, 32'h0000_00F3); // across the wrap
      push_req(0, 0, 0, 1, 32'h0000_00F4);
      push_req(0, 0, 0, 1, 32'hFFFF_FFFF);
      drain_all();

      write_reg(CSR_ENABLED, 16'(0));
      @(posedge clock);
      push_req(0, 0, 0, 1, 32'h0000_0100);
      push_req(1, 1, 0, 0, 32'h0000_0200);
      drain_all();

      write_reg(CSR_ENABLED, 16'(1));
      write_reg(CSR_FIRST_DELAY, 16'(0));
      write_reg(CSR_REPEAT_INTERVAL, 16'(0));
      write_reg(CSR_BUTTON_ONE_ID, 16'(31));
      write_reg(CSR_BUTTON_TWO_ID, 16'(0));
      for (int k = CSR_BUTTON_TWO_ID + 1; k < 2 ** CSR_IDX_W; k++)
         write_reg(CSR_IDX_W'(k), 16'($urandom));
      @(posedge clock);
      push_req(0, 0, 0, 1, 32'h0000_2000); // re-enable leaves timer stopped
      push_req(0, 1, 1, 0, 32'h0000_2001);
      push_req(0, 1, 0, 0, 32'h0000_2001);
      push_req(0, 1, 0, 0, 32'h0000_2001);
      drain_all();

      // sender light idle, receiver heavy idle
      write_reg(CSR_FIRST_DELAY, 16'(20));
      write_reg(CSR_REPEAT_INTERVAL, 16'(5));
      write_reg(CSR_BUTTON_ONE_ID, 16'(3));
      write_reg(CSR_BUTTON_TWO_ID, 16'(28));
      @(posedge clock);
      gen_presses(190, 8, 6);
      drain_all();
      random_setup();
      gen_presses(190, 10, 6);
      drain_all();

      // roles swapped, long delays and a disabled stretch
      set_idle(71, 32);
      write_reg(CSR_FIRST_DELAY, 16'hFFFF);
      write_reg(CSR_REPEAT_INTERVAL, 16'hFFFF);
      write_reg(CSR_BUTTON_ONE_ID, 16'(31));
      write_reg(CSR_BUTTON_TWO_ID, 16'(31));
      @(posedge clock);
      t_cursor = $urandom;
      gen_presses(190, 40000, 6);
      drain_all();
      write_reg(CSR_ENABLED, 16'(0));
      @(posedge clock);
      gen_presses(60, 10, 10);
      drain_all();
      write_reg(CSR_ENABLED, 16'(1));
      write_reg(CSR_FIRST_DELAY, 16'(7));
      write_reg(CSR_REPEAT_INTERVAL, 16'(3));
      @(posedge clock);
      gen_presses(130, 5, 6);
      drain_all();

      // no idling; receiver holds off while requests keep coming
      set_idle(0, 0);
      random_setup();
      t_cursor = $urandom;
      gen_presses(200, 8, 6);
      hold_asked++;
      drain_all();
      random_setup();
      gen_presses(190, 12, 6);
      drain_all();

      repeat (8) @(posedge clock);
      if (fail_cnt == 0 && fire_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
